### rtl/cbm_pkg.sv
`timescale 1ns / 1ps
// Cartridge bank mapper package: target codes, controller codes, register
// indexes and the bank state and result types. No dependencies.
package cbm_pkg;

  localparam logic [1:0] TGT_ROM  = 2'd0;
  localparam logic [1:0] TGT_RAM  = 2'd1;
  localparam logic [1:0] TGT_INT  = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  localparam logic [1:0] CT_NONE = 2'd0;
  localparam logic [1:0] CT_MBC1 = 2'd1;
  localparam logic [1:0] CT_MBC2 = 2'd2;
  localparam logic [1:0] CT_MBC3 = 2'd3;

  localparam logic CFG_CTRL_TYPE   = 1'b0;
  localparam logic CFG_RAM_PRESENT = 1'b1;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  typedef struct packed {
    logic       ram_en;
    logic [6:0] rom_low;
    logic [1:0] rom_high;
    logic [3:0] ram_bank;
    logic       mode;
  } bank_state_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mapped_addr;
    logic [7:0]  store_data;
    logic [8:0]  rom_bank_now;
    logic        ram_enabled_now;
  } result_t;

endpackage

### rtl/cbm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the cartridge bank mapper: bus access,
// result and configuration write. No dependencies.
interface cbm_access_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] bus_addr;
  logic [7:0]  wdata;
  modport source (output valid, output op, output bus_addr, output wdata, input ready);
  modport sink   (input valid, input op, input bus_addr, input wdata, output ready);
endinterface

interface cbm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  target;
  logic [20:0] mapped_addr;
  logic [7:0]  store_data;
  logic [8:0]  rom_bank_now;
  logic        ram_enabled_now;
  modport source (output valid, output target, output mapped_addr, output store_data,
                  output rom_bank_now, output ram_enabled_now, input ready);
  modport sink   (input valid, input target, input mapped_addr, input store_data,
                  input rom_bank_now, input ram_enabled_now, output ready);
endinterface

interface cbm_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cbm_decode.sv
`timescale 1ns / 1ps
// Combinational access decode: bank register update and target/address map.
// Depends on cbm_pkg.
module cbm_decode import cbm_pkg::*; (
  input  logic [1:0]  ctrl_type,
  input  logic        ram_present,
  input  bank_state_t bank,
  input  logic        op,
  input  logic [15:0] bus_addr,
  input  logic [7:0]  wdata,
  output bank_state_t bank_next,
  output result_t     res
);

  logic        in_ext;
  logic        ext_ok;
  logic [20:0] ext_addr;
  logic [20:0] rom_addr;
  logic [6:0]  low_val;

  assign in_ext = (bus_addr[15:13] == 3'b101);

  // external RAM window
  always_comb begin
    ext_ok   = 1'b0;
    ext_addr = '0;
    if (ram_present && bank.ram_en) begin
      if (ctrl_type == CT_MBC2) begin
        ext_ok   = 1'b1;
        ext_addr = {12'd0, bus_addr[8:0]};
      end else if (bank.ram_bank[3:2] == 2'b00) begin
        ext_ok   = 1'b1;
        ext_addr = {6'd0, bank.ram_bank[1:0], bus_addr[12:0]};
      end
    end
  end

  assign rom_addr = {bank.rom_high, 19'd0} | {bank.rom_low, 14'd0} | {7'd0, bus_addr[13:0]};

  // bank register writes
  always_comb begin
    bank_next = bank;
    low_val   = '0;
    if (op && !bus_addr[15]) begin
      if (bus_addr[14:13] == 2'd0) begin
        bank_next.ram_en = (wdata[3:0] == RAM_EN_KEY);
      end
      unique case (ctrl_type)
        CT_MBC1: begin
          unique case (bus_addr[14:13])
            2'd1: begin
              low_val = {2'd0, wdata[4:0]};
              bank_next.rom_low = (low_val == '0) ? 7'd1 : low_val;
            end
            2'd2: begin
              if (!bank.mode) bank_next.rom_high = wdata[1:0];
              else bank_next.ram_bank = {2'd0, wdata[1:0]};
            end
            2'd3: bank_next.mode = wdata[0];
            default: ;
          endcase
        end
        CT_MBC2: begin
          if (bus_addr[14:13] == 2'd1) begin
            low_val = {3'd0, wdata[3:0]};
            bank_next.rom_low  = (low_val == '0) ? 7'd1 : low_val;
            bank_next.rom_high = 2'd0;
          end
        end
        CT_MBC3: begin
          if (bus_addr[14:13] == 2'd1) begin
            low_val = wdata[6:0];
            bank_next.rom_low  = (low_val == '0) ? 7'd1 : low_val;
            bank_next.rom_high = 2'd0;
          end else if (bus_addr[14:13] == 2'd2) begin
            bank_next.ram_bank = wdata[3:0];
          end
        end
        default: ;
      endcase
    end
  end

  // target map
  always_comb begin
    res.target      = TGT_NONE;
    res.mapped_addr = '0;
    res.store_data  = '0;
    if (op) begin
      if (!bus_addr[15]) begin
        res.target = TGT_NONE;
      end else if (in_ext) begin
        if (ext_ok) begin
          res.target      = TGT_RAM;
          res.mapped_addr = ext_addr;
          res.store_data  = (ctrl_type == CT_MBC2) ? {4'd0, wdata[3:0]} : wdata;
        end
      end else begin
        res.target      = TGT_INT;
        res.mapped_addr = {5'd0, bus_addr};
        res.store_data  = wdata;
      end
    end else if (ctrl_type == CT_NONE) begin
      res.target      = bus_addr[15] ? TGT_INT : TGT_ROM;
      res.mapped_addr = {5'd0, bus_addr};
    end else if (bus_addr[15:14] == 2'b00) begin
      res.target      = TGT_ROM;
      res.mapped_addr = {5'd0, bus_addr};
    end else if (bus_addr[15:14] == 2'b01) begin
      res.target      = TGT_ROM;
      res.mapped_addr = rom_addr;
    end else if (in_ext) begin
      if (ext_ok) begin
        res.target      = TGT_RAM;
        res.mapped_addr = ext_addr;
      end
    end else begin
      res.target      = TGT_INT;
      res.mapped_addr = {5'd0, bus_addr};
    end
    res.rom_bank_now    = {2'd0, bank_next.rom_high, 5'd0} | {2'd0, bank_next.rom_low};
    res.ram_enabled_now = bank_next.ram_en;
  end

endmodule

### rtl/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// Cartridge bank mapper top level: bank registers, configuration and result
// register. Depends on cbm_pkg, cbm_if and cbm_decode.
//
// Usage:
//   req  - CPU bus access (op, bus_addr, wdata); one transfer per access.
//   rsp  - one result per access: target store, mapped address, masked write
//          data, current ROM bank and RAM enable after the access.
//   cfg  - register writes: index 0 controller type, index 1 RAM present.
//          Always ready; write only while no access is in flight.
// Latency: the result is valid the cycle after the access transfer.
// Throughput: one access per cycle while rsp is ready; the bank registers
//   and the decode are a single combinational step into the result register.
// Reset: controller type 0, no RAM, RAM disabled, ROM bank 1, RAM bank 0,
//   banking mode 1; no result pending.
// Stall: while rsp is held, the result register keeps its value and req is
//   ready only in the cycle the pending result is taken.
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cbm_cfg_if.sink   cfg,
  cbm_access_if.sink req,
  cbm_result_if.source rsp
);

  logic [1:0]  ctrl_type;
  logic        ram_present;
  bank_state_t bank;
  bank_state_t bank_next;
  result_t     res_next;
  result_t     res;
  logic        out_valid;
  logic        req_xfer;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || rsp.ready;
  assign req_xfer  = req.valid && req.ready;

  cbm_decode u_decode (
    .ctrl_type   (ctrl_type),
    .ram_present (ram_present),
    .bank        (bank),
    .op          (req.op),
    .bus_addr    (req.bus_addr),
    .wdata       (req.wdata),
    .bank_next   (bank_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_type   <= CT_NONE;
      ram_present <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CTRL_TYPE:   ctrl_type   <= cfg.data;
        CFG_RAM_PRESENT: ram_present <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank.ram_en   <= 1'b0;
      bank.rom_low  <= 7'd1;
      bank.rom_high <= 2'd0;
      bank.ram_bank <= 4'd0;
      bank.mode     <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (req_xfer) begin
        bank      <= bank_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      res <= res_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.target          = res.target;
  assign rsp.mapped_addr     = res.mapped_addr;
  assign rsp.store_data      = res.store_data;
  assign rsp.rom_bank_now    = res.rom_bank_now;
  assign rsp.ram_enabled_now = res.ram_enabled_now;

`ifndef SYNTHESIS
  a_low_nonzero: assert property (@(posedge clk) disable iff (rst)
    bank.rom_low != 7'd0)
    else $error("ROM bank low bits are zero");

  a_none_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.target == TGT_NONE |-> res.mapped_addr == '0 && res.store_data == '0)
    else $error("target none carries address or data");

  a_mbc2_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.target == TGT_RAM && ctrl_type == CT_MBC2
    |-> res.mapped_addr[20:9] == '0 && res.store_data[7:4] == '0)
    else $error("MBC2 RAM access out of range");

  a_enable_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.ram_enabled_now == bank.ram_en)
    else $error("reported RAM enable differs from state");

  a_bank_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res.rom_bank_now == ({2'd0, bank.rom_high, 5'd0} | {2'd0, bank.rom_low}))
    else $error("reported ROM bank differs from state");
`endif

endmodule
